// ----- design/ifd_pkg.sv -----
// image filter package: pixel and register field widths, register indexes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ifd_pkg;

    localparam int PIX_W     = 8;
    localparam int PIX_MAX   = 255;
    localparam int POS_W     = 13;
    localparam int ROW_W     = 14;
    localparam int DIVR_W    = 16;
    localparam int OFF_W     = 16;
    localparam int FSIZE_W   = 26;
    localparam int COEF_BITS_TOTAL = 200;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF0   = 3'd0,
        CFG_COEF1   = 3'd1,
        CFG_COEF2   = 3'd2,
        CFG_COEF3   = 3'd3,
        CFG_DIVISOR = 3'd4,
        CFG_OFFSET  = 3'd5,
        CFG_FSIZE   = 3'd6,
        CFG_RADII   = 3'd7
    } t_cfg_idx;

endpackage

`default_nettype wire

// ----- design/ifd_div.sv -----
// iterative restoring divider, one quotient bit per cycle
// no dependencies; used by the filter for the final scale
`timescale 1ns / 1ps
`default_nettype none

module ifd_div #(
    parameter int DW = 22,
    parameter int VW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output logic               o_done,
    output logic [DW-1:0]      o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [VW:0]   r_rem, n_rem;
    logic [DW-1:0] r_quo, n_quo;
    logic [VW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [VW:0]   rem_sh;

    always_comb begin
        rem_sh = {r_rem[VW-1:0], r_quo[DW-1]};
        if (rem_sh >= {1'b0, r_dvs}) begin
            n_rem = rem_sh - {1'b0, r_dvs};
            n_quo = {r_quo[DW-2:0], 1'b1};
        end else begin
            n_rem = rem_sh;
            n_quo = {r_quo[DW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;

endmodule

`default_nettype wire

// ----- design/image_filter_2d_top.sv -----
// image_filter_2d_top: streaming 2-d convolution filter with replicated borders
// depends on ifd_pkg and ifd_div
//
// Input channel (i_in_valid / o_in_ready) takes one word: a pixel in raster
// order (i_func = 0) or a drain word (i_func = 1) that releases one pending
// result once the whole frame is in. Output channel (o_out_valid /
// i_out_ready) gives filtered pixels in raster order with last_of_run on the
// final result a word caused and last_of_frame on the bottom-right pixel.
// Configuration is a plain write port (enable, index, 64-bit data).
// One word is worked on at a time; o_in_ready is high only when idle.
// A pixel word is stored in steps (accept, row slot, write) and, once enough
// rows are in, checked for a release; an ignored word ends at the row slot.
// Each result then takes one line store read per mask tap through a
// three-stage multiply-accumulate, one divider pass over the DW-bit sum
// (DW is 21 at default parameters) for the scale, and set-up and emit steps.
// A pixel word releases up to MAX_RADIUS+1 results; a drain word skips the
// store and goes straight to set-up of its result.
// The last result sits in the output register while the next word is taken;
// a stalled receiver holds the sequencer before the next result is loaded.
// Reset clears counters and configuration (the divisor resets to 1); the line store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module image_filter_2d_top
    import ifd_pkg::*;
#(
    parameter int MAX_RADIUS = 2,
    parameter int MAX_WIDTH  = 4096,
    parameter int COEF_BITS  = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_func,
    input  wire logic [PIX_W-1:0]     i_pixel_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [PIX_W-1:0]          o_pixel_out,
    output logic                      o_last_of_run,
    output logic                      o_last_of_frame
);

    localparam int LROWS  = 2 * MAX_RADIUS + 1;
    localparam int TAPS   = LROWS * LROWS;
    localparam int MAXOUT = MAX_RADIUS + 1;
    localparam int DEPTH  = LROWS * MAX_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int SLOT_W = $clog2(LROWS);
    localparam int KW     = $clog2(TAPS);
    localparam int IW     = $clog2(LROWS);
    localparam int RADW   = $clog2(MAX_RADIUS + 1);
    localparam int NW     = $clog2(MAXOUT + 1);
    localparam int SUM_W  = COEF_BITS + PIX_W + $clog2(TAPS);
    localparam int QW     = SUM_W + 1;
    localparam int RW     = ((QW > OFF_W) ? QW : OFF_W) + 1;
    localparam int CV_W   = TAPS * COEF_BITS;
    localparam int CAT_W  = (CV_W > COEF_BITS_TOTAL) ? CV_W : COEF_BITS_TOTAL;
    localparam int PW     = COEF_BITS + PIX_W + 1;
    localparam int UW     = ROW_W + 1;
    localparam int SLOT_SH  = POS_W + 5;
    localparam int SLOT_MUL = ((1 << SLOT_SH) + LROWS - 1) / LROWS;
    localparam int PRW      = POS_W + SLOT_SH;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_WMOD, S_CHECK, S_START, S_RMOD, S_TAPS, S_DIV, S_EMIT
    } t_state;

    // row modulo the line count by reciprocal multiplication
    function automatic logic [SLOT_W-1:0] row_slot(input logic [POS_W-1:0] v);
        logic [PRW-1:0]   prod;
        logic [POS_W-1:0] quo, rem;
        prod = PRW'(v) * PRW'(SLOT_MUL);
        quo  = prod[PRW-1:SLOT_SH];
        rem  = v - quo * POS_W'(LROWS);
        return rem[SLOT_W-1:0];
    endfunction

    // configuration
    logic [63:0]          r_coef0, r_coef1, r_coef2;
    logic [7:0]           r_coef3;
    logic [DIVR_W-1:0]    r_divisor;
    logic [OFF_W-1:0]     r_offset;
    logic [FSIZE_W-1:0]   r_fsize;
    logic [3:0]           r_radii;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef0   <= '0;
            r_coef1   <= '0;
            r_coef2   <= '0;
            r_coef3   <= '0;
            r_divisor <= DIVR_W'(1);
            r_offset  <= '0;
            r_fsize   <= '0;
            r_radii   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_COEF0:   r_coef0   <= i_cfg_data;
                CFG_COEF1:   r_coef1   <= i_cfg_data;
                CFG_COEF2:   r_coef2   <= i_cfg_data;
                CFG_COEF3:   r_coef3   <= i_cfg_data[7:0];
                CFG_DIVISOR: r_divisor <= i_cfg_data[DIVR_W-1:0];
                CFG_OFFSET:  r_offset  <= i_cfg_data[OFF_W-1:0];
                CFG_FSIZE:   r_fsize   <= i_cfg_data[FSIZE_W-1:0];
                CFG_RADII:   r_radii   <= i_cfg_data[3:0];
                default:     r_radii   <= r_radii;
            endcase
        end
    end

    // geometry
    logic [ROW_W-1:0] g_w, g_h, w_raw;
    logic [RADW-1:0]  g_rx, g_ry;
    logic [CAT_W-1:0] coef_cat;
    logic [CV_W-1:0]  coef_vec;
    logic [DIVR_W-1:0] div_eff;

    always_comb begin
        w_raw = ROW_W'(r_fsize[POS_W-1:0]) + 1'b1;
        g_w   = (w_raw > ROW_W'(MAX_WIDTH)) ? ROW_W'(MAX_WIDTH) : w_raw;
        g_h   = ROW_W'(r_fsize[2*POS_W-1:POS_W]) + 1'b1;
        g_rx  = (32'(r_radii[1:0]) > MAX_RADIUS) ? RADW'(MAX_RADIUS) : RADW'(r_radii[1:0]);
        g_ry  = (32'(r_radii[3:2]) > MAX_RADIUS) ? RADW'(MAX_RADIUS) : RADW'(r_radii[3:2]);
        coef_cat = CAT_W'({r_coef3, r_coef2, r_coef1, r_coef0});
        coef_vec = coef_cat[CV_W-1:0];
        div_eff  = (r_divisor == '0) ? DIVR_W'(1) : r_divisor;
    end

    // sequencer state
    t_state             r_state;
    logic               r_func, r_drain, r_in_done;
    logic [PIX_W-1:0]   r_pix;
    logic [POS_W-1:0]   r_in_col, r_out_col, r_out_row;
    logic [ROW_W-1:0]   r_in_row;
    logic [POS_W-1:0]   r_cx, r_cy, r_ox, r_oy;
    logic [NW-1:0]      r_n;
    logic [SLOT_W-1:0]  r_slot;
    logic [AW-1:0]      r_base;
    logic signed [UW-1:0] r_u;
    logic [IW-1:0]      r_i, r_j;
    logic [KW-1:0]      r_k;
    logic               r_issue_done;
    logic               r_v1, r_v2;
    logic signed [COEF_BITS-1:0] r_c1;
    logic [PIX_W-1:0]   r_rd;
    logic signed [PW-1:0] r_prod;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [QW-1:0] r_q;
    logic               r_out_v, r_out_last, r_out_fin;
    logic [PIX_W-1:0]   r_out_pix;

    // single divider for the final scale
    logic              div_start, div_done;
    logic [SUM_W-1:0]  div_dividend, div_q;
    logic [DIVR_W-1:0] div_divisor;

    ifd_div #(.DW(SUM_W), .VW(DIVR_W)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_q)
    );

    // combinational helpers
    logic [POS_W-1:0] in_cx, in_cy, cur_ox, cur_oy, row0;
    logic [ROW_W-1:0] col_raw, col_v;
    logic [AW-1:0]    rd_addr, wr_addr, slot_base;
    logic             issue, mem_we, taps_end;
    logic [SUM_W-1:0] mag;
    logic signed [UW-1:0] u_next;
    logic             step_row;
    logic             row_end, fin, cont;
    logic [POS_W-1:0] next_col;
    logic signed [RW-1:0] res;
    logic [PIX_W-1:0] res_pix;
    logic             out_free;

    always_comb begin
        in_cx  = (ROW_W'(r_in_col) < g_w) ? r_in_col : POS_W'(g_w - 1'b1);
        in_cy  = (r_in_row < g_h) ? r_in_row[POS_W-1:0] : POS_W'(g_h - 1'b1);
        cur_ox = (ROW_W'(r_out_col) < g_w) ? r_out_col : POS_W'(g_w - 1'b1);
        cur_oy = (ROW_W'(r_out_row) < g_h) ? r_out_row : POS_W'(g_h - 1'b1);
        row0   = (cur_oy < POS_W'(g_ry)) ? '0 : cur_oy - POS_W'(g_ry);

        slot_base = AW'(32'(r_slot) * MAX_WIDTH);
        wr_addr   = slot_base + AW'(r_cx);
        mem_we    = (r_state == S_WMOD);

        // replicated column of the current tap
        col_raw = ROW_W'(r_ox) + ROW_W'(r_j);
        if (col_raw < ROW_W'(g_rx)) begin
            col_v = '0;
        end else if (col_raw - ROW_W'(g_rx) > g_w - 1'b1) begin
            col_v = g_w - 1'b1;
        end else begin
            col_v = col_raw - ROW_W'(g_rx);
        end
        rd_addr  = r_base + AW'(col_v);
        issue    = (r_state == S_TAPS) && !r_issue_done;
        taps_end = (r_state == S_TAPS) && r_issue_done && !r_v1 && !r_v2;

        // the row slot moves on only while the window row lies inside the frame
        u_next   = r_u + UW'(1);
        step_row = (u_next >= UW'(1)) && (u_next <= $signed(UW'(g_h - 1'b1)));

        mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);

        div_start    = taps_end;
        div_dividend = mag;
        div_divisor  = div_eff;

        row_end  = (ROW_W'(r_ox) == g_w - 1'b1);
        fin      = row_end && (ROW_W'(r_oy) == g_h - 1'b1);
        next_col = r_ox + 1'b1;
        cont     = !r_drain && !row_end && (32'(r_n) + 1 < MAXOUT)
                   && ((ROW_W'(next_col) + ROW_W'(g_rx) <= ROW_W'(r_cx))
                       || (ROW_W'(r_cx) == g_w - 1'b1));

        res = RW'(r_q) + RW'($signed(r_offset));
        if (res < 0) begin
            res_pix = '0;
        end else if (res > RW'(PIX_MAX)) begin
            res_pix = PIX_W'(PIX_MAX);
        end else begin
            res_pix = res[PIX_W-1:0];
        end

        out_free = !r_out_v || i_out_ready;
    end

    // line store
    logic [PIX_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= r_pix;
        end
        if (issue) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_done   <= 1'b0;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_out_v     <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_drain     <= 1'b0;
            r_n         <= '0;
            r_issue_done <= 1'b0;
        end else begin
            // a word loaded in S_EMIT takes the register over
            if (r_out_v && i_out_ready && (r_state != S_EMIT)) begin
                r_out_v <= 1'b0;
            end

            // multiply-accumulate pipe
            r_v1 <= issue;
            if (issue) begin
                r_c1 <= $signed(coef_vec[r_k*COEF_BITS +: COEF_BITS]);
            end
            r_v2 <= r_v1;
            if (r_v1) begin
                r_prod <= r_c1 * $signed({1'b0, r_rd});
            end
            if (r_v2) begin
                r_sum <= r_sum + SUM_W'(r_prod);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_func  <= i_func;
                        r_pix   <= i_pixel_in;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_n     <= '0;
                    r_drain <= r_func;
                    if (r_in_done == r_func) begin
                        r_state <= r_func ? S_START : S_WMOD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                    r_cx   <= in_cx;
                    r_cy   <= in_cy;
                    r_slot <= row_slot(in_cy);
                end
                S_WMOD: begin
                    if (ROW_W'(r_cx) == g_w - 1'b1) begin
                        r_in_col <= '0;
                        r_in_row <= ROW_W'(r_cy) + 1'b1;
                        if (ROW_W'(r_cy) == g_h - 1'b1) begin
                            r_in_done <= 1'b1;
                        end
                    end else begin
                        r_in_col <= r_cx + 1'b1;
                    end
                    r_state <= (r_cy >= POS_W'(g_ry)) ? S_CHECK : S_IDLE;
                end
                S_CHECK: begin
                    if ((ROW_W'(cur_ox) + ROW_W'(g_rx) <= ROW_W'(r_cx))
                        || (ROW_W'(r_cx) == g_w - 1'b1)) begin
                        r_state <= S_START;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_START: begin
                    r_ox    <= cur_ox;
                    r_oy    <= cur_oy;
                    r_u     <= $signed(UW'(cur_oy)) - $signed(UW'(g_ry));
                    r_slot  <= row_slot(row0);
                    r_state <= S_RMOD;
                end
                S_RMOD: begin
                    r_base       <= slot_base;
                    r_i          <= '0;
                    r_j          <= '0;
                    r_k          <= '0;
                    r_sum        <= '0;
                    r_issue_done <= 1'b0;
                    r_state      <= S_TAPS;
                end
                S_TAPS: begin
                    if (issue) begin
                        r_k <= r_k + 1'b1;
                        if (r_j == IW'(2 * g_rx)) begin
                            r_j <= '0;
                            if (r_i == IW'(2 * g_ry)) begin
                                r_issue_done <= 1'b1;
                            end else begin
                                r_i <= r_i + 1'b1;
                                r_u <= u_next;
                                if (step_row) begin
                                    r_base <= (r_base == AW'((LROWS - 1) * MAX_WIDTH))
                                              ? '0 : r_base + AW'(MAX_WIDTH);
                                end
                            end
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                    if (taps_end) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_q <= r_sum[SUM_W-1] ? -$signed({1'b0, div_q})
                                              : $signed({1'b0, div_q});
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_v    <= 1'b1;
                        r_out_pix  <= res_pix;
                        r_out_fin  <= fin;
                        r_out_last <= fin || !cont;
                        r_n        <= r_n + 1'b1;
                        if (fin) begin
                            r_in_col  <= '0;
                            r_in_row  <= '0;
                            r_out_col <= '0;
                            r_out_row <= '0;
                            r_in_done <= 1'b0;
                            r_state   <= S_IDLE;
                        end else begin
                            if (row_end) begin
                                r_out_col <= '0;
                                r_out_row <= r_oy + 1'b1;
                            end else begin
                                r_out_col <= next_col;
                            end
                            r_state <= cont ? S_START : S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_v;
    assign o_pixel_out     = r_out_pix;
    assign o_last_of_run   = r_out_last;
    assign o_last_of_frame = r_out_fin;

endmodule

`default_nettype wire

// ----- tb/tb_image_filter_2d_top.sv -----
// testbench for image_filter_2d_top: random and directed frames checked
// against an in-bench convolution predictor; depends on ifd_pkg and the design
`timescale 1ns / 1ps

module tb_image_filter_2d_top
    import ifd_pkg::*;
();

    localparam int MAX_RAD   = 2;
    localparam int MAX_W     = 4096;
    localparam int LINE_ROWS = 2 * MAX_RAD + 1;
    localparam int MAX_OUT   = MAX_RAD + 1;
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             run_end;
        logic             frame_end;
    } t_filt_px;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 in_func;
    logic [PIX_W-1:0]     in_pixel;
    logic                 out_valid;
    logic                 out_ready;
    logic [PIX_W-1:0]     out_pixel;
    logic                 out_run_end;
    logic                 out_frame_end;

    image_filter_2d_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_func         (in_func),
        .i_pixel_in     (in_pixel),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_pixel_out    (out_pixel),
        .o_last_of_run  (out_run_end),
        .o_last_of_frame(out_frame_end)
    );

    // predictor state
    logic [COEF_BITS_TOTAL-1:0] mask_bits;
    logic [DIVR_W-1:0]          scale;
    logic [OFF_W-1:0]           bias;
    logic [FSIZE_W-1:0]         fsize;
    logic [3:0]                 radii;
    logic [PIX_W-1:0]           line_px [0:LINE_ROWS*MAX_W-1];
    int                         in_col, in_row, out_col, out_row;
    bit                         frame_in;
    int                         gw, gh, grx, gry;

    t_filt_px filt_q[$];
    int       errors;
    int       n_words;
    bit       no_idle;
    bit       hold_req;
    int       hold_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int clampc(int v, int n);
        if (v < 0) return 0;
        if (v > n - 1) return n - 1;
        return v;
    endfunction

    function automatic void load_geom();
        gw  = int'(fsize[12:0]) + 1;
        if (gw > MAX_W) gw = MAX_W;
        gh  = int'(fsize[25:13]) + 1;
        grx = (int'(radii[1:0]) > MAX_RAD) ? MAX_RAD : int'(radii[1:0]);
        gry = (int'(radii[3:2]) > MAX_RAD) ? MAX_RAD : int'(radii[3:2]);
    endfunction

    function automatic logic [PIX_W-1:0] filter_px(int x, int y);
        longint acc, q, d;
        int r, c, k;
        logic signed [7:0] cf;
        acc = 0;
        k = 0;
        for (int i = 0; i < 2 * gry + 1; i++) begin
            r = clampc(y + i - gry, gh);
            for (int j = 0; j < 2 * grx + 1; j++) begin
                c  = clampc(x + j - grx, gw);
                cf = mask_bits[k*8 +: 8];
                acc += longint'(cf) * longint'(line_px[(r % LINE_ROWS) * MAX_W + c]);
                k++;
            end
        end
        d = longint'(scale);
        if (d == 0) d = 1;
        q = acc / d + longint'($signed(bias));
        if (q < 0) q = 0;
        if (q > PIX_MAX) q = PIX_MAX;
        return q[PIX_W-1:0];
    endfunction

    function automatic t_filt_px next_result(output bit row_end);
        t_filt_px res;
        int ox, oy;
        ox = (out_col < gw) ? out_col : gw - 1;
        oy = (out_row < gh) ? out_row : gh - 1;
        res.pix       = filter_px(ox, oy);
        res.run_end   = 1'b0;
        res.frame_end = (ox == gw - 1) && (oy == gh - 1);
        row_end = (ox == gw - 1);
        if (row_end) begin
            out_col = 0;
            out_row = oy + 1;
        end else begin
            out_col = ox + 1;
        end
        return res;
    endfunction

    function automatic void predict_word(logic f, logic [PIX_W-1:0] p);
        t_filt_px res[$];
        t_filt_px r1;
        bit row_end;
        int cx, cy, ox;
        load_geom();
        if (f == FUNC_PIXEL) begin
            if (frame_in) return;
            cx = (in_col < gw) ? in_col : gw - 1;
            cy = (in_row < gh) ? in_row : gh - 1;
            line_px[(cy % LINE_ROWS) * MAX_W + cx] = p;
            if (cx == gw - 1) begin
                in_col = 0;
                in_row = cy + 1;
                if (cy == gh - 1) frame_in = 1;
            end else begin
                in_col = cx + 1;
            end
            if (cy >= gry) begin
                while (res.size() < MAX_OUT) begin
                    ox = (out_col < gw) ? out_col : gw - 1;
                    if (!(ox + grx <= cx || cx == gw - 1)) break;
                    r1 = next_result(row_end);
                    res.push_back(r1);
                    if (r1.frame_end || row_end) break;
                end
            end
        end else begin
            if (!frame_in) return;
            res.push_back(next_result(row_end));
        end
        if (res.size() > 0) begin
            res[res.size()-1].run_end = 1'b1;
            if (res[res.size()-1].frame_end) begin
                in_col = 0; in_row = 0; out_col = 0; out_row = 0;
                frame_in = 0;
            end
        end
        foreach (res[i]) filt_q.push_back(res[i]);
    endfunction

    // result checker
    always @(posedge i_clk) begin : check_out
        t_filt_px e;
        if (i_rst_n && out_valid && out_ready) begin
            if (filt_q.size() == 0) begin
                $error("unexpected word: pixel_out %0d", out_pixel);
                errors++;
            end else begin
                e = filt_q.pop_front();
                if (out_pixel !== e.pix) begin
                    $error("pixel_out: expected %0d, got %0d", e.pix, out_pixel);
                    errors++;
                end
                if (out_run_end !== e.run_end) begin
                    $error("last_of_run: expected %0d, got %0d", e.run_end, out_run_end);
                    errors++;
                end
                if (out_frame_end !== e.frame_end) begin
                    $error("last_of_frame: expected %0d, got %0d",
                           e.frame_end, out_frame_end);
                    errors++;
                end
            end
        end
    end

    // receiver back-pressure, long holds counted here
    initial begin : sink_ready
        int r;
        out_ready = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 0;
                hold_left = 1500;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (no_idle) begin
                out_ready <= 1'b1;
            end else begin
                r = $urandom_range(99);
                out_ready <= (r < 75);
                if (r >= 97) hold_left = $urandom_range(40, 10);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic send_word(input logic f, input logic [PIX_W-1:0] p);
        int g;
        g = pick_gap();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_func  <= f;
        in_pixel <= p;
        do @(posedge i_clk); while (!in_ready);
        predict_word(f, p);
        n_words++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (filt_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DAT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_COEF0:   mask_bits[63:0]    = val;
            CFG_COEF1:   mask_bits[127:64]  = val;
            CFG_COEF2:   mask_bits[191:128] = val;
            CFG_COEF3:   mask_bits[199:192] = val[7:0];
            CFG_DIVISOR: scale = val[DIVR_W-1:0];
            CFG_OFFSET:  bias  = val[OFF_W-1:0];
            CFG_FSIZE:   fsize = val[FSIZE_W-1:0];
            CFG_RADII:   radii = val[3:0];
            default: ;
        endcase
    endtask

    task automatic set_frame(input int w, input int h, input logic [3:0] rd);
        write_reg(CFG_FSIZE, {38'd0, 13'(h - 1), 13'(w - 1)});
        write_reg(CFG_RADII, {60'd0, rd});
    endtask

    task automatic set_mask(input logic [COEF_BITS_TOTAL-1:0] m);
        write_reg(CFG_COEF0, m[63:0]);
        write_reg(CFG_COEF1, m[127:64]);
        write_reg(CFG_COEF2, m[191:128]);
        write_reg(CFG_COEF3, {56'd0, m[199:192]});
    endtask

    // one whole frame; noisy frames add early drains and ignored pixels
    task automatic run_frame(input bit extremes, input bit noisy, input int pause_at);
        int npx;
        npx = gw * gh;
        for (int i = 0; i < npx; i++) begin
            if (noisy && $urandom_range(19) == 0) send_word(FUNC_DRAIN, 8'($urandom));
            if (i == pause_at) settle();
            send_word(FUNC_PIXEL, extremes ? ($urandom_range(1) ? 8'hff : 8'h00)
                                           : 8'($urandom));
        end
        while (frame_in) begin
            if (noisy && $urandom_range(9) == 0) send_word(FUNC_PIXEL, 8'($urandom));
            send_word(FUNC_DRAIN, 8'($urandom));
        end
    endtask

    task automatic test_defaults();
        load_geom();
        send_word(FUNC_PIXEL, 8'hff);
        send_word(FUNC_DRAIN, 8'h00);
        settle();
    endtask

    task automatic test_identity();
        logic [COEF_BITS_TOTAL-1:0] m;
        m = '0;
        m[12*8 +: 8] = 8'd1;
        set_mask(m);
        write_reg(CFG_DIVISOR, 64'd1);
        write_reg(CFG_OFFSET, 64'd0);
        set_frame(4, 3, 4'hf);
        load_geom();
        run_frame(1, 0, -1);
        settle();
    endtask

    task automatic test_saturation();
        set_mask({25{8'h7f}});
        write_reg(CFG_DIVISOR, 64'd0);
        write_reg(CFG_OFFSET, 64'h8000);
        set_frame(3, 2, 4'h5);
        load_geom();
        run_frame(1, 0, -1);
        settle();
        set_mask({25{8'h80}});
        write_reg(CFG_DIVISOR, 64'hffff);
        write_reg(CFG_OFFSET, 64'h7fff);
        set_frame(2, 2, 4'ha);
        load_geom();
        run_frame(1, 0, -1);
        settle();
    endtask

    // frame completes before any result; stray words either side
    task automatic test_stray_words();
        set_mask({25{8'h01}});
        write_reg(CFG_DIVISOR, 64'd9);
        write_reg(CFG_OFFSET, 64'hfffb);
        set_frame(3, 2, 4'h8);
        load_geom();
        send_word(FUNC_DRAIN, 8'h55);
        for (int i = 0; i < 6; i++) send_word(FUNC_PIXEL, 8'($urandom));
        send_word(FUNC_PIXEL, 8'haa);
        while (frame_in) send_word(FUNC_DRAIN, 8'h00);
        settle();
    endtask

    task automatic test_random();
        int w, h, frames, pause_at;
        logic [15:0] dv;
        frames = 0;
        while (n_words < 450) begin
            set_mask({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      8'($urandom)});
            case ($urandom_range(9))
                0:       dv = 16'd0;
                1:       dv = 16'($urandom);
                default: dv = 16'($urandom_range(64, 1));
            endcase
            write_reg(CFG_DIVISOR, {48'd0, dv});
            write_reg(CFG_OFFSET, {48'd0, ($urandom_range(3) == 0) ? 16'($urandom)
                                       : 16'($signed($urandom_range(80)) - 40)});
            w = ($urandom_range(7) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
            h = $urandom_range(6, 1);
            set_frame(w, h, 4'($urandom));
            load_geom();
            no_idle  = ($urandom_range(4) == 0);
            pause_at = (frames == 2) ? (gw * gh) / 2 : -1;
            if (frames == 4) hold_req = 1;
            run_frame(0, $urandom_range(2) == 0, pause_at);
            no_idle = 0;
            settle();
            frames++;
        end
    endtask

    initial begin
        errors    = 0;
        n_words   = 0;
        no_idle   = 0;
        hold_req  = 0;
        i_rst_n   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_COEF0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_func   = FUNC_PIXEL;
        in_pixel  = '0;
        mask_bits = '0;
        scale     = 16'd1;
        bias      = '0;
        fsize     = '0;
        radii     = '0;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        frame_in  = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_identity();
        test_saturation();
        test_stray_words();
        test_random();

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
